/* rtl/hst_pkg.sv */
// Shared constants, codes and types of the handle slot table.
package hst_pkg;

  // Field widths.
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 8;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Default table size and the width of one group of the free-slot search.
  localparam int TABLE_SLOTS = 32;
  localparam int GROUP_SIZE  = 16;
  localparam int GROUP_POS_W = 4;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_GET    = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Outcome of the search for the lowest empty slot.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] index;
  } free_find_t;

endpackage

/* rtl/hst_free_find.sv */
// Two-level search for the lowest empty slot, with the group summary registered.
module hst_free_find #(
  parameter int CAPACITY = hst_pkg::TABLE_SLOTS
) (
  input  logic                 clk,
  input  logic [CAPACITY-1:0]  occ,
  output hst_pkg::free_find_t  result
);
  import hst_pkg::*;

  localparam int NGROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_W   = NGROUPS * GROUP_SIZE;

  logic [PAD_W-1:0]       occ_pad;
  logic [NGROUPS-1:0]     grp_any_next;
  logic [GROUP_POS_W-1:0] grp_pos_next [NGROUPS];
  logic [NGROUPS-1:0]     grp_any;
  logic [GROUP_POS_W-1:0] grp_pos [NGROUPS];

  // Slots past the end of the table are padded as occupied so they are never chosen.
  always_comb begin
    occ_pad = '1;
    occ_pad[CAPACITY-1:0] = occ;
  end

  // First level: lowest empty position inside each group of sixteen slots.
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_any_next[g] = 1'b0;
      grp_pos_next[g] = '0;
      for (int p = GROUP_SIZE - 1; p >= 0; p--) begin
        if (!occ_pad[g*GROUP_SIZE + p]) begin
          grp_any_next[g] = 1'b1;
          grp_pos_next[g] = GROUP_POS_W'(p);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
    for (int g = 0; g < NGROUPS; g++) begin
      grp_pos[g] <= grp_pos_next[g];
    end
  end

  // Second level: lowest group that holds an empty slot.
  always_comb begin
    result.found = 1'b0;
    result.index = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        result.found = 1'b1;
        result.index = SLOT_W'(g * GROUP_SIZE) + SLOT_W'(grp_pos[g]);
      end
    end
  end

endmodule

/* rtl/handle_slot_table.sv */
// Top level of the handle slot table: command sequencer, slot memory and occupancy bits.
//
//  Channel   Handshake         Payload
//  -------   ---------------   ---------------------------------
//  command   start / busy      func, slot, payload
//  result    done (strobe)     status, slot_out, read_value
//
// Each command passes through two steps: the first reads the slot memory and
// registers the free-slot group summary, the second decides, writes back and
// registers the result. The result strobe follows in the next cycle, and busy
// is already low in that cycle, so a new command can be taken while it is shown.
// Reset clears the occupancy bits at once; the memory itself needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module handle_slot_table #(
  parameter int CAPACITY = hst_pkg::TABLE_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [hst_pkg::FUNC_W-1:0]    func,
  input  logic [hst_pkg::SLOT_W-1:0]    slot,
  input  logic [hst_pkg::DATA_W-1:0]    payload,
  output logic                          done,
  output logic [hst_pkg::STATUS_W-1:0]  status,
  output logic [hst_pkg::SLOT_W-1:0]    slot_out,
  output logic [hst_pkg::DATA_W-1:0]    read_value
);
  import hst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic                state;
  logic                state_next;
  logic [FUNC_W-1:0]   func_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [DATA_W-1:0]   payload_q;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] occ_next;
  logic [DATA_W-1:0]   mem [CAPACITY];
  logic [DATA_W-1:0]   rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                accept;
  logic                in_range;
  logic [IDX_W-1:0]    slot_idx;
  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_out_next;
  logic [DATA_W-1:0]   read_value_next;
  free_find_t          ff;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Free-slot search over the occupancy bits.
  hst_free_find #(
    .CAPACITY(CAPACITY)
  ) u_free_find (
    .clk    (clk),
    .occ    (occ),
    .result (ff)
  );

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[slot[IDX_W-1:0]];
  end

  // Command capture on each transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= func;
      slot_q    <= slot;
      payload_q <= payload;
    end
  end

  assign in_range = ({1'b0, slot_q} < (SLOT_W+1)'(CAPACITY));
  assign slot_idx = slot_q[IDX_W-1:0];

  // Decision, write-back and result for the command in flight.
  always_comb begin
    state_next      = state;
    occ_next        = occ;
    mem_we          = 1'b0;
    mem_waddr       = slot_idx;
    mem_wdata       = '0;
    status_next     = ST_OK;
    slot_out_next   = '0;
    read_value_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_IDLE;
        case (func_q)
          OP_INSERT: begin
            if (ff.found) begin
              mem_we                         = 1'b1;
              mem_waddr                      = ff.index[IDX_W-1:0];
              mem_wdata                      = payload_q;
              occ_next[ff.index[IDX_W-1:0]]  = (payload_q != '0);
              slot_out_next                  = ff.index;
            end else begin
              status_next = ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (!in_range) begin
              status_next = ST_RANGE;
            end else begin
              mem_we             = 1'b1;
              occ_next[slot_idx] = 1'b0;
            end
          end
          OP_GET: begin
            if (!in_range) begin
              status_next = ST_RANGE;
            end else if (!occ[slot_idx]) begin
              status_next = ST_EMPTY;
            end else begin
              read_value_next = rd_data;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      done  <= (state == S_LOOK);
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      status     <= status_next;
      slot_out   <= slot_out_next;
      read_value <= read_value_next;
    end
  end

  // Every accepted command produces a result strobe once its look state is over.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted command gave no result");

  // The result strobe never overlaps a command in flight.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A full report only comes when every slot is occupied.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (&occ))
    else $error("table reported full with an empty slot");

  // A successful get never returns an empty word.
  a_get_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && func_q == OP_GET && in_range && occ[slot_idx]) |-> (rd_data != '0))
    else $error("occupied slot holds zero");

endmodule
